FILE: rtl/fba_pkg.sv
package fba_pkg;

    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int STRATEGY_W = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_STRATEGY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [STRATEGY_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_BEST  = 2'd3
    } strategy_t;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
    } item_t;

    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   chosen_block;
        logic [AMOUNT_W-1:0] leftover;
    } result_t;

    // table strobes from the sequencer
    typedef struct packed {
        logic load;
        logic read;
        logic grant;
    } tbl_ctl_t;

endpackage

FILE: rtl/fba_table.sv
module fba_table #(
    parameter int MAX_BLOCKS = fba_pkg::DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = fba_pkg::DEF_SIZE_BITS,
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fba_pkg::tbl_ctl_t    ctl,
    input  logic [IDX_W-1:0]     load_addr,
    input  logic [SIZE_BITS-1:0] load_size,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic [IDX_W-1:0]     grant_addr,
    output logic [SIZE_BITS-1:0] rd_size,
    output logic                 rd_taken
);
    import fba_pkg::*;

    logic [SIZE_BITS-1:0]  size_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] taken_reg;
    logic [SIZE_BITS-1:0]  rd_size_reg;
    logic                  rd_taken_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            size_mem[load_addr] <= load_size;
        end
        if (ctl.read)
        begin
            rd_size_reg <= size_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg    <= '0;
            rd_taken_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                taken_reg[load_addr] <= 1'b0;
            end
            if (ctl.grant)
            begin
                taken_reg[grant_addr] <= 1'b1;
            end
            if (ctl.read)
            begin
                rd_taken_reg <= taken_reg[rd_addr];
            end
        end
    end

    assign rd_size  = rd_size_reg;
    assign rd_taken = rd_taken_reg;

endmodule

FILE: rtl/fba_cmp.sv
module fba_cmp #(
    parameter int SIZE_BITS = fba_pkg::DEF_SIZE_BITS
) (
    input  fba_pkg::strategy_t          strategy,
    input  logic [SIZE_BITS-1:0]        size,
    input  logic                        taken,
    input  logic [fba_pkg::AMOUNT_W-1:0] amount,
    input  logic [SIZE_BITS-1:0]        pick_size,
    output logic                        fit,
    output logic                        better,
    output logic [fba_pkg::AMOUNT_W-1:0] leftover
);
    import fba_pkg::*;

    localparam int CW = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    logic [CW-1:0] size_w;
    logic [CW-1:0] pick_w;
    logic [CW-1:0] amount_w;
    logic [CW-1:0] diff_w;

    always_comb
    begin
        size_w   = CW'(size);
        pick_w   = CW'(pick_size);
        amount_w = CW'(amount);
        diff_w   = pick_w - amount_w;
        fit      = !taken && (size_w >= amount_w);
        leftover = diff_w[AMOUNT_W-1:0];
        case (strategy) inside
            FIT_FIRST, FIT_NEXT: better = 1'b0;
            FIT_WORST:           better = size_w > pick_w;
            default:             better = size_w < pick_w;
        endcase
    end

endmodule

FILE: rtl/fba_ctrl.sv
module fba_ctrl #(
    parameter int MAX_BLOCKS = fba_pkg::DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = fba_pkg::DEF_SIZE_BITS,
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fba_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  fba_pkg::item_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output fba_pkg::result_t              rsp,
    output fba_pkg::tbl_ctl_t             tbl_ctl,
    output logic [IDX_W-1:0]              load_addr,
    output logic [SIZE_BITS-1:0]          load_size,
    output logic [IDX_W-1:0]              rd_addr,
    output logic [IDX_W-1:0]              grant_addr,
    output fba_pkg::strategy_t            strategy,
    output logic [fba_pkg::AMOUNT_W-1:0]  amount,
    output logic [SIZE_BITS-1:0]          pick_size,
    input  logic [SIZE_BITS-1:0]          rd_size,
    input  logic                          fit,
    input  logic                          better,
    input  logic [fba_pkg::AMOUNT_W-1:0]  leftover
);
    import fba_pkg::*;

    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    strategy_t            strategy_reg, strategy_next;
    logic [COUNT_W-1:0]   block_count_reg, block_count_next;
    logic [SLOT_W-1:0]    next_start_reg, next_start_next;
    logic [AMOUNT_W-1:0]  amount_reg, amount_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     issued_reg, issued_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    result_t              rsp_reg, rsp_next;

    logic [CNT_W-1:0] live;
    logic [CNT_W-1:0] addr_inc;
    logic             accept;
    logic             hit;
    logic             take;
    logic             early;
    logic             issue;
    logic             out_free;

    always_comb
    begin
        state_next       = state_reg;
        strategy_next    = strategy_reg;
        block_count_next = block_count_reg;
        next_start_next  = next_start_reg;
        amount_next      = amount_reg;
        count_next       = count_reg;
        issued_next      = issued_reg;
        addr_next        = addr_reg;
        pend_next        = 1'b0;
        pend_idx_next    = addr_reg;
        found_next       = found_reg;
        pick_next        = pick_reg;
        pick_size_next   = pick_size_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_next         = rsp_reg;
        tbl_ctl          = '0;

        live = (CMP_W'(block_count_reg) > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : CNT_W'(block_count_reg);
        addr_inc = CNT_W'(addr_reg) + CNT_W'(1);
        accept   = req_valid && (state_reg == ST_IDLE);
        out_free = !rsp_valid_reg || !rsp_stall;

        hit   = (state_reg == ST_SCAN) && pend_reg && fit;
        take  = hit && (!found_reg || better);
        early = ((strategy_reg == FIT_FIRST) || (strategy_reg == FIT_NEXT))
                && (found_reg || hit);
        issue = (state_reg == ST_SCAN) && (issued_reg != count_reg) && !early;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STRATEGY:    strategy_next    = strategy_t'(cfg_data[STRATEGY_W-1:0]);
                REG_BLOCK_COUNT: block_count_next = cfg_data[COUNT_W-1:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_LOAD)
                    begin
                        tbl_ctl.load = 32'(req.slot) < 32'(MAX_BLOCKS);
                    end
                    else
                    begin
                        amount_next = req.amount;
                        count_next  = live;
                        issued_next = '0;
                        found_next  = 1'b0;
                        if ((strategy_reg == FIT_NEXT) && (32'(next_start_reg) < 32'(live)))
                        begin
                            addr_next = IDX_W'(next_start_reg);
                        end
                        else
                        begin
                            addr_next = '0;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_next      = pend_idx_reg;
                    pick_size_next = rd_size;
                end
                if (issue)
                begin
                    tbl_ctl.read = 1'b1;
                    pend_next    = 1'b1;
                    issued_next  = issued_reg + CNT_W'(1);
                    addr_next    = (addr_inc == count_reg) ? '0 : addr_inc[IDX_W-1:0];
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.granted      = found_reg;
                    rsp_next.chosen_block = found_reg ? SLOT_W'(pick_reg) : '0;
                    rsp_next.leftover     = found_reg ? leftover : '0;
                    tbl_ctl.grant = found_reg;
                    if (found_reg && (strategy_reg == FIT_NEXT))
                    begin
                        next_start_next = SLOT_W'(pick_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            strategy_reg    <= FIT_FIRST;
            block_count_reg <= '0;
            next_start_reg  <= '0;
            amount_reg      <= '0;
            count_reg       <= '0;
            issued_reg      <= '0;
            addr_reg        <= '0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            found_reg       <= 1'b0;
            pick_reg        <= '0;
            pick_size_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            strategy_reg    <= strategy_next;
            block_count_reg <= block_count_next;
            next_start_reg  <= next_start_next;
            amount_reg      <= amount_next;
            count_reg       <= count_next;
            issued_reg      <= issued_next;
            addr_reg        <= addr_next;
            pend_reg        <= pend_next;
            pend_idx_reg    <= pend_idx_next;
            found_reg       <= found_next;
            pick_reg        <= pick_next;
            pick_size_reg   <= pick_size_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
        end
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign load_addr  = IDX_W'(req.slot);
    assign load_size  = SIZE_BITS'(req.amount);
    assign rd_addr    = addr_reg;
    assign grant_addr = pick_reg;
    assign strategy   = strategy_reg;
    assign amount     = amount_reg;
    assign pick_size  = pick_size_reg;

endmodule

FILE: rtl/fit_block_allocator_top.sv
// channel | valid     | stall     | payload
// --------+-----------+-----------+-------------------------------
// req     | req_valid | req_stall | req (kind, slot, amount)
// rsp     | rsp_valid | rsp_stall | rsp (granted, chosen_block, leftover)
// cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// Load transaction: written to the table on acceptance, sequencer stays idle, no response.
// Request transaction: the next accept waits for the scan, which reads one block per cycle
//   through the size memory's single read port; all live
//   blocks are read, but first and next fit stop at the read that hits.
// A full response register holds the sequencer in its final state until taken.
// Reset clears taken marks, next-fit pointer and registers; sizes are unset until loaded.
module fit_block_allocator_top #(
    parameter int MAX_BLOCKS = fba_pkg::DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = fba_pkg::DEF_SIZE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fba_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  fba_pkg::item_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output fba_pkg::result_t              rsp
);
    import fba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    tbl_ctl_t             tbl_ctl;
    logic [IDX_W-1:0]     load_addr;
    logic [SIZE_BITS-1:0] load_size;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     grant_addr;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 rd_taken;
    strategy_t            strategy;
    logic [AMOUNT_W-1:0]  amount;
    logic [SIZE_BITS-1:0] pick_size;
    logic                 fit;
    logic                 better;
    logic [AMOUNT_W-1:0]  leftover;

    fba_table #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tbl_ctl),
        .load_addr  (load_addr),
        .load_size  (load_size),
        .rd_addr    (rd_addr),
        .grant_addr (grant_addr),
        .rd_size    (rd_size),
        .rd_taken   (rd_taken)
    );

    fba_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .strategy  (strategy),
        .size      (rd_size),
        .taken     (rd_taken),
        .amount    (amount),
        .pick_size (pick_size),
        .fit       (fit),
        .better    (better),
        .leftover  (leftover)
    );

    fba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .tbl_ctl    (tbl_ctl),
        .load_addr  (load_addr),
        .load_size  (load_size),
        .rd_addr    (rd_addr),
        .grant_addr (grant_addr),
        .strategy   (strategy),
        .amount     (amount),
        .pick_size  (pick_size),
        .rd_size    (rd_size),
        .fit        (fit),
        .better     (better),
        .leftover   (leftover)
    );

    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.kind == KIND_REQUEST) |=> req_stall)
        else $error("request transaction did not start a scan");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.kind == KIND_LOAD && !rsp_valid) |=> !rsp_valid)
        else $error("load transaction produced a response");

    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.granted) |-> (rsp.chosen_block == '0 && rsp.leftover == '0))
        else $error("refused request carries block or leftover");

endmodule

FILE: tb/sv/tb_fit_block_allocator_top.sv
module tb_fit_block_allocator_top;
    import fba_pkg::*;

    localparam int BLOCKS        = DEF_MAX_BLOCKS;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 106;
    localparam int PLAN_ROWS     = 35;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        item_t                it;
        logic                 typed;
        result_t              res;
    } step_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    item_t                req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    result_t              rsp;

    // allocator state as the testbench sees it
    strategy_t            fit_mode  = FIT_FIRST;
    logic [COUNT_W-1:0]   count_reg = '0;
    logic [SLOT_W-1:0]    next_ptr  = '0;
    logic [AMOUNT_W-1:0]  blk_size [BLOCKS];
    bit                   blk_taken [BLOCKS];

    result_t              pending_allocs [$];
    result_t              head_res;
    int                   mismatches   = 0;
    int                   cycles       = 0;
    int                   tx_idle_pct  = 0;
    int                   rx_stall_pct = 0;

    fit_block_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_fit_block_allocator_top: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < rx_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_allocs.size() == 0)
            begin
                $error("unexpected transaction: granted %0d chosen_block %0d leftover %0d",
                       rsp.granted, rsp.chosen_block, rsp.leftover);
                mismatches++;
            end
            else
            begin
                head_res = pending_allocs.pop_front();
                if (rsp.granted !== head_res.granted)
                begin
                    $error("granted: expected %0d, got %0d", head_res.granted, rsp.granted);
                    mismatches++;
                end
                if (rsp.chosen_block !== head_res.chosen_block)
                begin
                    $error("chosen_block: expected %0d, got %0d",
                           head_res.chosen_block, rsp.chosen_block);
                    mismatches++;
                end
                if (rsp.leftover !== head_res.leftover)
                begin
                    $error("leftover: expected %0d, got %0d", head_res.leftover, rsp.leftover);
                    mismatches++;
                end
            end
        end
    end

    function automatic bit is_free_fit(input int b, input logic [AMOUNT_W-1:0] amt);
        return !blk_taken[b] && blk_size[b] >= amt;
    endfunction

    function automatic void predict_alloc(input item_t it, output bit makes_res,
                                          output result_t res);
        int  live;
        int  start;
        int  i;
        int  pick;
        bit  found;
        res       = '0;
        makes_res = 1'b0;
        found     = 1'b0;
        pick      = 0;
        live      = (int'(count_reg) > BLOCKS) ? BLOCKS : int'(count_reg);
        if (it.kind == KIND_LOAD)
        begin
            blk_size[it.slot]  = it.amount;
            blk_taken[it.slot] = 1'b0;
            return;
        end
        makes_res = 1'b1;
        case (fit_mode)
            FIT_FIRST:
                for (i = 0; i < live && !found; i++)
                    if (is_free_fit(i, it.amount))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
            FIT_NEXT:
            begin
                start = (int'(next_ptr) < live) ? int'(next_ptr) : 0;
                for (int n = 0; n < live && !found; n++)
                begin
                    i = start + n;
                    if (i >= live)
                        i -= live;
                    if (is_free_fit(i, it.amount))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                if (found)
                    next_ptr = SLOT_W'(pick);
            end
            FIT_WORST:
                for (i = 0; i < live; i++)
                    if (is_free_fit(i, it.amount) && (!found || blk_size[i] > blk_size[pick]))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
            default:
                for (i = 0; i < live; i++)
                    if (is_free_fit(i, it.amount) && (!found || blk_size[i] < blk_size[pick]))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
        endcase
        if (found)
        begin
            blk_taken[pick]  = 1'b1;
            res.granted      = 1'b1;
            res.chosen_block = SLOT_W'(pick);
            res.leftover     = blk_size[pick] - it.amount;
        end
    endfunction

    function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        step_t s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val[CFG_W-1:0];
        return s;
    endfunction

    function automatic step_t item_row(input logic kind, input int slot, input int amt);
        step_t s;
        s           = '0;
        s.it.kind   = kind;
        s.it.slot   = slot[SLOT_W-1:0];
        s.it.amount = amt[AMOUNT_W-1:0];
        return s;
    endfunction

    function automatic step_t known_row(input int slot, input int amt, input logic g,
                                        input int blk, input int left);
        step_t s;
        s                  = item_row(KIND_REQUEST, slot, amt);
        s.typed            = 1'b1;
        s.res.granted      = g;
        s.res.chosen_block = blk[SLOT_W-1:0];
        s.res.leftover     = left[AMOUNT_W-1:0];
        return s;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
        bit      makes_res;
        result_t got;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_alloc(it, makes_res, got);
        if (makes_res)
            pending_allocs.push_back(typed ? typed_res : got);
        @(negedge clk);
    endtask

    // wait until every request transaction has come back and the scan is certainly idle
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_STRATEGY)
            fit_mode = strategy_t'(val[STRATEGY_W-1:0]);
        else
            count_reg = val[COUNT_W-1:0];
    endtask

    initial
    begin
        step_t               plan [PLAN_ROWS];
        int                  counts [PHASES];
        item_t               it;
        logic [AMOUNT_W-1:0] ref_size;
        int                  r;

        plan = '{
            cfg_row(REG_STRATEGY, FIT_FIRST),
            cfg_row(REG_BLOCK_COUNT, 0),
            known_row(15, 1, 1'b0, 0, 0),
            item_row(KIND_LOAD, 0, 65535),
            item_row(KIND_LOAD, 1, 300),
            item_row(KIND_LOAD, 2, 300),
            item_row(KIND_LOAD, 3, 0),
            item_row(KIND_LOAD, 15, 65535),
            cfg_row(REG_BLOCK_COUNT, 4),
            known_row(0, 65535, 1'b1, 0, 0),
            known_row(15, 65535, 1'b0, 0, 0),
            item_row(KIND_REQUEST, 0, 0),
            item_row(KIND_LOAD, 0, 65535),
            cfg_row(REG_STRATEGY, FIT_WORST),
            known_row(0, 0, 1'b1, 0, 65535),
            cfg_row(REG_STRATEGY, FIT_BEST),
            item_row(KIND_REQUEST, 0, 0),
            item_row(KIND_LOAD, 1, 300),
            item_row(KIND_REQUEST, 0, 299),
            cfg_row(REG_STRATEGY, FIT_NEXT),
            item_row(KIND_LOAD, 3, 10),
            item_row(KIND_REQUEST, 0, 5),
            item_row(KIND_REQUEST, 0, 5),
            item_row(KIND_LOAD, 0, 50),
            item_row(KIND_REQUEST, 0, 5),
            item_row(KIND_LOAD, 3, 20),
            item_row(KIND_REQUEST, 0, 20),
            cfg_row(REG_BLOCK_COUNT, 2),
            item_row(KIND_LOAD, 1, 7),
            item_row(KIND_REQUEST, 0, 1),
            cfg_row(REG_BLOCK_COUNT, 4),
            cfg_row(REG_STRATEGY, FIT_WORST),
            item_row(KIND_LOAD, 1, 500),
            item_row(KIND_LOAD, 2, 500),
            item_row(KIND_REQUEST, 0, 500)
        };
        counts = '{16, 31, 1, 0, 17, 8, 16, 3, 16, 12, 2, 16, 5, 16, 31, 16};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
            begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end
            else
                send_item(plan[k].it, plan[k].typed, plan[k].res);
        end

        // every slot gets a size before a wide scan can reach it
        for (int s = 0; s < BLOCKS; s++)
        begin
            it.kind   = KIND_LOAD;
            it.slot   = SLOT_W'(s);
            it.amount = AMOUNT_W'($urandom_range(65535));
            send_item(it, 1'b0, '0);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            tx_idle_pct  = (p / 4 == 1) ? 77 : (p / 4 == 3) ? 7 : 0;
            rx_stall_pct = (p / 4 == 2) ? 77 : (p / 4 == 3) ? 7 : 0;
            write_reg(REG_STRATEGY, CFG_W'(p % 4));
            write_reg(REG_BLOCK_COUNT, CFG_W'(counts[p]));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    settle();
                r       = $urandom_range(99);
                it.slot = SLOT_W'($urandom_range(15));
                if (r < 45)
                begin
                    it.kind = KIND_LOAD;
                    case ($urandom_range(9))
                        0:       it.amount = '0;
                        1:       it.amount = '1;
                        2, 3:    it.amount = AMOUNT_W'(256 << $urandom_range(2));
                        4, 5, 6: it.amount = AMOUNT_W'($urandom_range(1000));
                        default: it.amount = AMOUNT_W'($urandom_range(65535));
                    endcase
                end
                else
                begin
                    it.kind  = KIND_REQUEST;
                    ref_size = blk_size[$urandom_range(BLOCKS - 1)];
                    case ($urandom_range(9))
                        0:          it.amount = '0;
                        1:          it.amount = '1;
                        2, 3:       it.amount = ref_size;
                        4, 5, 6, 7: it.amount = AMOUNT_W'($urandom_range(ref_size));
                        default:    it.amount = AMOUNT_W'($urandom_range(65535));
                    endcase
                end
                send_item(it, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("tb_fit_block_allocator_top: done, clean");
        else
            $display("tb_fit_block_allocator_top: done, errors");
        $finish;
    end

endmodule
